// ===== hdl/modbus_ascii_frame_decoder_defines.svh =====
// assertion macros for the modbus ascii frame decoder
`ifndef MODBUS_ASCII_FRAME_DECODER_DEFINES_SVH
`define MODBUS_ASCII_FRAME_DECODER_DEFINES_SVH

`ifndef SYNTH
// check on every clock edge once reset is released
`define MAFD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// check on every clock edge, reset included
`define MAFD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define MAFD_ASSERT(lbl, clk, rstn, prop, msg)
`define MAFD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== hdl/mafd_pkg.sv =====
package mafd_pkg;

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;

    localparam logic [7:0] MAX_DATA_LEN_RESET = 8'd20;
    localparam logic [8:0] BYTES_SATURATE     = 9'd511;
    localparam logic [8:0] HEADER_BYTES       = 9'd3;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_LRC       = 3'd1,
        ST_LONG      = 3'd2,
        ST_SHORT     = 3'd3,
        ST_MALFORMED = 3'd4,
        ST_ABORTED   = 3'd5
    } t_status;

    typedef struct packed {
        logic       is_colon;
        logic       is_cr;
        logic       is_lf;
        logic [3:0] nibble;
    } t_char_info;

    typedef struct packed {
        logic       result_kind;
        logic [7:0] data_byte;
        logic [7:0] byte_pos;
        logic [7:0] frame_address;
        logic [7:0] frame_function;
        logic [7:0] data_count;
        t_status    frame_status;
    } t_result;

endpackage

// ===== hdl/mafd_char_class.sv =====
module mafd_char_class
    import mafd_pkg::*;
(
    input  logic [7:0] i_char,
    output t_char_info o_info
);

    always_comb begin
        o_info.is_colon = (i_char == CHAR_COLON);
        o_info.is_cr    = (i_char == CHAR_CR);
        o_info.is_lf    = (i_char == CHAR_LF);
        if (i_char >= 8'h30 && i_char <= 8'h39) begin
            o_info.nibble = i_char[3:0];
        end else if ((i_char >= 8'h61 && i_char <= 8'h66)
                  || (i_char >= 8'h41 && i_char <= 8'h46)) begin
            // letters a-f and A-F share the low bits 1..6
            o_info.nibble = i_char[3:0] + 4'd9;
        end else begin
            o_info.nibble = 4'd0;
        end
    end

endmodule

// ===== hdl/mafd_frame_core.sv =====
`include "modbus_ascii_frame_decoder_defines.svh"

module mafd_frame_core
    import mafd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  t_char_info i_info,
    input  logic [7:0] i_max_data_len,
    output logic       o_res_valid,
    output t_result    o_res
);

    logic       r_in_frame,  n_in_frame;
    logic       r_second,    n_second;
    logic [3:0] r_high,      n_high;
    logic [8:0] r_bytes,     n_bytes;
    logic [7:0] r_addr,      n_addr;
    logic [7:0] r_func,      n_func;
    logic [7:0] r_pending,   n_pending;
    logic [7:0] r_sum,       n_sum;
    logic       r_saw_cr,    n_saw_cr;
    t_status    r_err,       n_err;

    logic [8:0] bytes_m3;
    logic [7:0] data_given;
    logic       idx_in_range;
    logic [7:0] new_byte;
    logic       lf_end;
    t_status    err;
    t_status    end_status;

    assign bytes_m3     = r_bytes - HEADER_BYTES;
    assign idx_in_range = (bytes_m3 < {1'b0, i_max_data_len});
    assign new_byte     = {r_high, i_info.nibble};

    always_comb begin
        if (r_bytes < HEADER_BYTES) begin
            data_given = 8'd0;
        end else if (idx_in_range) begin
            data_given = bytes_m3[7:0];
        end else begin
            data_given = i_max_data_len;
        end
    end

    always_comb begin
        if (r_err != ST_OK) begin
            end_status = r_err;
        end else if (r_bytes < HEADER_BYTES) begin
            end_status = ST_SHORT;
        end else if (r_sum == r_pending) begin
            end_status = ST_OK;
        end else begin
            end_status = ST_LRC;
        end
    end

    always_comb begin
        n_in_frame = r_in_frame;
        n_second   = r_second;
        n_high     = r_high;
        n_bytes    = r_bytes;
        n_addr     = r_addr;
        n_func     = r_func;
        n_pending  = r_pending;
        n_sum      = r_sum;
        n_saw_cr   = r_saw_cr;
        n_err      = r_err;
        err        = r_err;
        lf_end     = 1'b0;

        o_res_valid          = 1'b0;
        o_res.result_kind    = KIND_END;
        o_res.data_byte      = 8'd0;
        o_res.byte_pos       = 8'd0;
        o_res.frame_address  = r_addr;
        o_res.frame_function = r_func;
        o_res.data_count     = data_given;
        o_res.frame_status   = ST_ABORTED;

        if (i_info.is_colon) begin
            o_res_valid = r_in_frame;
            n_in_frame  = 1'b1;
            n_second    = 1'b0;
            n_high      = 4'd0;
            n_bytes     = 9'd0;
            n_addr      = 8'd0;
            n_func      = 8'd0;
            n_pending   = 8'd0;
            n_sum       = 8'd0;
            n_saw_cr    = 1'b0;
            n_err       = ST_OK;
        end else if (r_in_frame) begin
            if (r_saw_cr) begin
                n_saw_cr = 1'b0;
                if (i_info.is_lf) begin
                    lf_end             = 1'b1;
                    o_res_valid        = 1'b1;
                    o_res.frame_status = end_status;
                    n_in_frame         = 1'b0;
                end else if (err == ST_OK) begin
                    err = ST_MALFORMED;
                end
            end
            if (!lf_end) begin
                if (i_info.is_cr) begin
                    if (r_second && err == ST_OK) begin
                        err = ST_MALFORMED;
                    end
                    n_saw_cr = 1'b1;
                end else if (!r_second) begin
                    n_high   = i_info.nibble;
                    n_second = 1'b1;
                end else begin
                    n_second = 1'b0;
                    if (r_bytes == 9'd0) begin
                        n_addr = new_byte;
                        n_sum  = new_byte;
                    end else if (r_bytes == 9'd1) begin
                        n_func = new_byte;
                        n_sum  = r_sum + new_byte;
                    end else begin
                        if (r_bytes >= HEADER_BYTES) begin
                            if (idx_in_range) begin
                                o_res_valid        = 1'b1;
                                o_res.result_kind  = KIND_DATA;
                                o_res.data_byte    = r_pending;
                                o_res.byte_pos     = bytes_m3[7:0];
                                o_res.data_count   = 8'd0;
                                o_res.frame_status = ST_OK;
                                n_sum              = r_sum + r_pending;
                            end else if (err == ST_OK) begin
                                err = ST_LONG;
                            end
                        end
                        n_pending = new_byte;
                    end
                    if (r_bytes != BYTES_SATURATE) begin
                        n_bytes = r_bytes + 9'd1;
                    end
                end
            end
            n_err = err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_second   <= 1'b0;
            r_high     <= 4'd0;
            r_bytes    <= 9'd0;
            r_addr     <= 8'd0;
            r_func     <= 8'd0;
            r_pending  <= 8'd0;
            r_sum      <= 8'd0;
            r_saw_cr   <= 1'b0;
            r_err      <= ST_OK;
        end else if (i_step) begin
            r_in_frame <= n_in_frame;
            r_second   <= n_second;
            r_high     <= n_high;
            r_bytes    <= n_bytes;
            r_addr     <= n_addr;
            r_func     <= n_func;
            r_pending  <= n_pending;
            r_sum      <= n_sum;
            r_saw_cr   <= n_saw_cr;
            r_err      <= n_err;
        end
    end

    `MAFD_ASSERT(a_data_in_frame, i_clk, i_rst_n, (o_res_valid && o_res.result_kind == KIND_DATA) |-> (r_in_frame && r_bytes >= HEADER_BYTES), "data byte outside a frame")
    `MAFD_ASSERT(a_byte_pos_range, i_clk, i_rst_n, (o_res_valid && o_res.result_kind == KIND_DATA) |-> (o_res.byte_pos < i_max_data_len), "data position beyond limit")
    `MAFD_ASSERT(a_lf_closes_frame, i_clk, i_rst_n, (i_step && o_res_valid && o_res.result_kind == KIND_END && !i_info.is_colon) |=> !r_in_frame, "frame still open after end report")
    `MAFD_ASSERT(a_colon_opens_frame, i_clk, i_rst_n, (i_step && i_info.is_colon) |=> (r_in_frame && r_bytes == 9'd0 && r_err == ST_OK), "colon did not restart frame")

endmodule

// ===== hdl/modbus_ascii_frame_decoder.sv =====
// modbus ascii frame decoder: takes one received character per transaction and gives out
// confirmed data bytes (one hex pair late) and an end-of-frame report with status. one
// character per cycle is sustained unless stalled; each character is held in the input
// register and decoded in a single pass into the result register. the input side stalls
// only when a character would reach a full result register that is itself stalled. the
// user must write max_data_len via i_cfg_wr_en/i_cfg_wr_data while idle; not checked.
module modbus_ascii_frame_decoder
    import mafd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_rx_char,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_result_kind,
    output logic [7:0] o_data_byte,
    output logic [7:0] o_byte_pos,
    output logic [7:0] o_frame_address,
    output logic [7:0] o_frame_function,
    output logic [7:0] o_data_count,
    output logic [2:0] o_frame_status
);

    logic [7:0] r_max_data_len;
    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_out_valid;
    t_result    r_out;

    logic       core_ready;
    logic       step;
    t_char_info info;
    logic       res_valid;
    t_result    res;

    assign core_ready = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && core_ready;
    assign o_in_stall = r_in_valid && !core_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_data_len <= MAX_DATA_LEN_RESET;
        end else if (i_cfg_wr_en) begin
            r_max_data_len <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_char <= i_rx_char;
        end
    end

    mafd_char_class u_char_class (
        .i_char (r_in_char),
        .o_info (info)
    );

    mafd_frame_core u_frame_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_info         (info),
        .i_max_data_len (r_max_data_len),
        .o_res_valid    (res_valid),
        .o_res          (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_result_kind    = r_out.result_kind;
    assign o_data_byte      = r_out.data_byte;
    assign o_byte_pos       = r_out.byte_pos;
    assign o_frame_address  = r_out.frame_address;
    assign o_frame_function = r_out.frame_function;
    assign o_data_count     = r_out.data_count;
    assign o_frame_status   = r_out.frame_status;

endmodule

// ===== tb/sv/tb_modbus_ascii_frame_decoder.sv =====
`timescale 1ns / 100ps

module tb_modbus_ascii_frame_decoder
    import mafd_pkg::*;
();

    localparam int IDLE_LIMIT    = 1000;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 8;
    localparam int REPORT_LIMIT  = 10;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_wr_en;
    logic [7:0] i_cfg_wr_data;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [7:0] i_rx_char;
    logic       o_out_valid;
    logic       i_out_stall;
    logic       o_result_kind;
    logic [7:0] o_data_byte;
    logic [7:0] o_byte_pos;
    logic [7:0] o_frame_address;
    logic [7:0] o_frame_function;
    logic [7:0] o_data_count;
    logic [2:0] o_frame_status;

    // decoder state as predicted, starting from the reset values
    logic [7:0] dec_max_len   = MAX_DATA_LEN_RESET;
    logic       dec_in_frame  = 1'b0;
    logic       dec_low_half  = 1'b0;
    logic [3:0] dec_high_nib  = 4'h0;
    logic [8:0] dec_byte_count = 9'd0;
    logic [7:0] dec_addr      = 8'h00;
    logic [7:0] dec_func      = 8'h00;
    logic [7:0] dec_last_byte = 8'h00;
    logic [7:0] dec_sum       = 8'h00;
    logic       dec_cr_seen   = 1'b0;
    t_status    dec_error     = ST_OK;

    t_result    frame_results_due[$];
    logic [7:0] frame_bytes[$];
    logic [7:0] frame_chars[$];

    t_result    seen_result;
    t_result    due_result;
    int         mismatch_count = 0;
    int         idle_cycles;
    logic       gaps_on;

    modbus_ascii_frame_decoder dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_rx_char        (i_rx_char),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_result_kind    (o_result_kind),
        .o_data_byte      (o_data_byte),
        .o_byte_pos       (o_byte_pos),
        .o_frame_address  (o_frame_address),
        .o_frame_function (o_frame_function),
        .o_data_count     (o_data_count),
        .o_frame_status   (o_frame_status)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) return "0" + {4'h0, v};
        return ($urandom_range(0, 1) ? "a" : "A") + {4'h0, v} - 8'd10;
    endfunction

    function automatic string show_result(input t_result r);
        string head;
        head = $sformatf("kind %0d byte %h pos %0d", r.result_kind, r.data_byte, r.byte_pos);
        return {head, $sformatf(" addr %h func %h count %0d status %0d", r.frame_address,
                                r.frame_function, r.data_count, r.frame_status)};
    endfunction

    task automatic push_frame_end(input t_status st);
        t_result    r;
        logic [8:0] given;
        r = '0;
        r.result_kind    = KIND_END;
        r.frame_address  = dec_addr;
        r.frame_function = dec_func;
        r.frame_status   = st;
        if (dec_byte_count >= HEADER_BYTES) begin
            given = dec_byte_count - HEADER_BYTES;
            if (given > {1'b0, dec_max_len}) given = {1'b0, dec_max_len};
            r.data_count = given[7:0];
        end
        frame_results_due.push_back(r);
    endtask

    task automatic decode_char(input logic [7:0] c);
        t_result    r;
        t_status    st;
        logic [3:0] nib;
        logic [7:0] b;
        logic [8:0] idx;
        logic       closed;
        closed = 1'b0;
        if (c == CHAR_COLON) begin
            if (dec_in_frame) push_frame_end(ST_ABORTED);
            dec_in_frame   = 1'b1;
            dec_low_half   = 1'b0;
            dec_high_nib   = 4'h0;
            dec_byte_count = 9'd0;
            dec_addr       = 8'h00;
            dec_func       = 8'h00;
            dec_last_byte  = 8'h00;
            dec_sum        = 8'h00;
            dec_cr_seen    = 1'b0;
            dec_error      = ST_OK;
        end else if (dec_in_frame) begin
            if (dec_cr_seen) begin
                dec_cr_seen = 1'b0;
                if (c == CHAR_LF) begin
                    if (dec_error != ST_OK) st = dec_error;
                    else if (dec_byte_count < HEADER_BYTES) st = ST_SHORT;
                    else if (dec_sum == dec_last_byte) st = ST_OK;
                    else st = ST_LRC;
                    push_frame_end(st);
                    dec_in_frame = 1'b0;
                    closed = 1'b1;
                end else if (dec_error == ST_OK) begin
                    dec_error = ST_MALFORMED;
                end
            end
            if (!closed && c == CHAR_CR) begin
                if (dec_low_half && dec_error == ST_OK) dec_error = ST_MALFORMED;
                dec_cr_seen = 1'b1;
            end else if (!closed) begin
                // anything that is not a hex digit decodes as zero
                if (c >= "0" && c <= "9") nib = c[3:0];
                else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F"))
                    nib = c[3:0] + 4'd9;
                else nib = 4'h0;
                if (!dec_low_half) begin
                    dec_high_nib = nib;
                    dec_low_half = 1'b1;
                end else begin
                    dec_low_half = 1'b0;
                    b = {dec_high_nib, nib};
                    if (dec_byte_count == 9'd0) begin
                        dec_addr = b;
                        dec_sum  = b;
                    end else if (dec_byte_count == 9'd1) begin
                        dec_func = b;
                        dec_sum  = dec_sum + b;
                    end else begin
                        // previous byte is now known to be data, not the lrc
                        if (dec_byte_count >= HEADER_BYTES) begin
                            idx = dec_byte_count - HEADER_BYTES;
                            if (idx < {1'b0, dec_max_len}) begin
                                r = '0;
                                r.result_kind    = KIND_DATA;
                                r.data_byte      = dec_last_byte;
                                r.byte_pos       = idx[7:0];
                                r.frame_address  = dec_addr;
                                r.frame_function = dec_func;
                                r.frame_status   = ST_OK;
                                frame_results_due.push_back(r);
                                dec_sum = dec_sum + dec_last_byte;
                            end else if (dec_error == ST_OK) begin
                                dec_error = ST_LONG;
                            end
                        end
                        dec_last_byte = b;
                    end
                    if (dec_byte_count < BYTES_SATURATE) dec_byte_count = dec_byte_count + 9'd1;
                end
            end
        end
    endtask

    task automatic send_char(input logic [7:0] c);
        int gap;
        gap = (gaps_on && $urandom_range(0, 1)) ? pick_gap() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_char  <= c;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        decode_char(c);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i]);
    endtask

    task automatic send_frame_chars();
        foreach (frame_chars[i]) send_char(frame_chars[i]);
    endtask

    task automatic push_hex(input logic [7:0] b);
        frame_chars.push_back(hex_char(b[7:4]));
        frame_chars.push_back(hex_char(b[3:0]));
    endtask

    task automatic wait_until_idle();
        i_in_valid <= 1'b0;
        while (frame_results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_max_len(input logic [7:0] v);
        wait_until_idle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        dec_max_len = v;
    endtask

    task automatic send_random_frame();
        logic [7:0] sum;
        logic [7:0] noise;
        int         n, lim, flaw, pos, keep;
        frame_bytes.delete();
        frame_chars.delete();
        gaps_on = ($urandom_range(0, 3) != 0);
        // line noise between frames
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                do noise = 8'($urandom); while (noise == CHAR_COLON);
                send_char(noise);
            end
        end
        lim = (dec_max_len < 12) ? dec_max_len : 12;
        if ($urandom_range(0, 9) == 0 && dec_max_len < 40) n = dec_max_len + $urandom_range(1, 3);
        else n = $urandom_range(0, lim);
        frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(8'($urandom));
        repeat (n) frame_bytes.push_back(8'($urandom));
        sum = 8'h00;
        foreach (frame_bytes[i]) sum = sum + frame_bytes[i];
        if ($urandom_range(0, 3) == 0) frame_bytes.push_back(8'($urandom));
        else frame_bytes.push_back(sum);
        flaw = $urandom_range(0, 99);
        if (flaw >= 70 && flaw < 75) begin
            keep = $urandom_range(0, 2);
            while (frame_bytes.size() > keep) frame_bytes.pop_back();
        end
        frame_chars.push_back(CHAR_COLON);
        foreach (frame_bytes[i]) push_hex(frame_bytes[i]);
        frame_chars.push_back(CHAR_CR);
        frame_chars.push_back(CHAR_LF);
        pos = $urandom_range(1, frame_chars.size() - 2);
        if (flaw >= 75 && flaw < 80) begin
            do noise = 8'($urandom); while (noise == CHAR_COLON);
            frame_chars.insert(pos, noise);
        end else if (flaw >= 80 && flaw < 85) begin
            frame_chars.insert(pos, $urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
        end else if (flaw >= 85 && flaw < 90) begin
            // cr followed by something other than lf, then a proper end
            frame_chars.insert(frame_chars.size() - 1, hex_char(4'($urandom)));
            frame_chars.push_back(CHAR_CR);
            frame_chars.push_back(CHAR_LF);
        end else if (flaw >= 90 && flaw < 95 && frame_chars.size() > 3) begin
            frame_chars.delete(pos);
        end else if (flaw >= 95 && flaw < 98) begin
            frame_chars.pop_back();
            frame_chars.pop_back();
        end else if (flaw >= 98) begin
            frame_chars.insert(pos, CHAR_COLON);
        end
        send_frame_chars();
    endtask

    task automatic test_special_cases();
        gaps_on = 1'b1;
        // ignored character outside a frame, then cr in mid pair
        send_text("Z:0");
        send_char(CHAR_CR);
        send_char(CHAR_LF);
        // colon inside a frame, stray lf, cr not followed by lf
        send_text(":01:FFfe");
        send_char(CHAR_LF);
        send_text("000");
        send_char(CHAR_CR);
        send_text("X");
        send_char(CHAR_CR);
        send_char(CHAR_LF);
        // too short, then a good lrc with no data
        send_text(":0000");
        send_char(CHAR_CR);
        send_char(CHAR_LF);
        send_text(":7F80FF");
        send_char(CHAR_CR);
        send_char(CHAR_LF);
    endtask

    task automatic test_length_limits();
        // widest limit with a frame long enough to saturate the byte count
        write_max_len(8'd255);
        gaps_on = 1'b0;
        frame_chars.delete();
        frame_chars.push_back(CHAR_COLON);
        repeat (515) push_hex(8'($urandom));
        frame_chars.push_back(CHAR_CR);
        frame_chars.push_back(CHAR_LF);
        send_frame_chars();
        write_max_len(8'd0);
        gaps_on = 1'b1;
        send_text(":0102AA03");
        send_char(CHAR_CR);
        send_char(CHAR_LF);
        send_text(":010203");
        send_char(CHAR_CR);
        send_char(CHAR_LF);
    endtask

    task automatic test_random_traffic(input logic [7:0] len, input int items);
        int sent;
        write_max_len(len);
        sent = 0;
        while (sent < items) begin
            send_random_frame();
            sent = sent + frame_chars.size();
        end
    endtask

    // result side back-pressure
    initial begin
        int free;
        i_out_stall <= 1'b0;
        @(posedge i_rst_n);
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 19) == 0) free = $urandom_range(100, 300);
            else free = $urandom_range(1, 8);
            repeat (free) @(posedge i_clk);
            i_out_stall <= 1'b1;
            repeat (pick_gap()) @(posedge i_clk);
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            seen_result = {o_result_kind, o_data_byte, o_byte_pos, o_frame_address,
                           o_frame_function, o_data_count, o_frame_status};
            if (frame_results_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected transaction: %s", show_result(seen_result));
            end else begin
                due_result = frame_results_due.pop_front();
                if (seen_result !== due_result) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("mismatch exp: %s", show_result(due_result));
                        $display("         act: %s", show_result(seen_result));
                    end
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    initial begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid === 1'b1 && o_in_stall === 1'b0) ||
                (o_out_valid === 1'b1 && i_out_stall === 1'b0))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("** modbus_ascii_frame_decoder: FAILED **");
        $finish;
    end

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= 8'h00;
        i_in_valid    <= 1'b0;
        i_rx_char     <= 8'h00;
        gaps_on = 1'b1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);
        test_special_cases();
        test_length_limits();
        test_random_traffic(MAX_DATA_LEN_RESET, 100);
        test_random_traffic(8'd0, 80);
        test_random_traffic(8'd255, 100);
        test_random_traffic(8'd1, 80);
        test_random_traffic(8'($urandom_range(2, 254)), 100);
        test_random_traffic(8'd5, 100);
        wait_until_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && frame_results_due.size() == 0)
            $display("** modbus_ascii_frame_decoder: PASSED **");
        else
            $display("** modbus_ascii_frame_decoder: FAILED **");
        $finish;
    end

endmodule
